### hdl/gcr_pkg.sv
`timescale 1ns / 1ps
package gcr_pkg;

    localparam int AXES         = 6;
    localparam int SAMPLE_W     = 16;
    localparam int OUT_W        = 24;
    localparam int ROW_W        = 6;
    localparam int CNT_W        = 7;
    localparam int DEF_OUT_ROWS = 64;
    localparam int FRAC_W       = 8;
    // dividend of the interpolation term: |diff * rem| << 8 stays below 2^30
    localparam int DIV_W        = 31;
    localparam int QDEPTH       = 4;

    typedef logic [AXES-1:0][SAMPLE_W-1:0] sample_vec_t;
    typedef logic [AXES-1:0][OUT_W-1:0]    result_vec_t;

    typedef enum logic {
        CMD_WRITE,
        CMD_RUN
    } cmd_kind_t;

    // cnt is the store row for a write and the sample count for a run
    typedef struct packed {
        cmd_kind_t   kind;
        logic [CNT_W-1:0] cnt;
        sample_vec_t data;
    } cmd_t;

endpackage

### hdl/gesture_capture_resampler.sv
`timescale 1ns / 1ps
// Capture ticks are taken while the queue has room; a four-entry command queue absorbs them
// while a run is busy. A release after stored samples starts a run of OUT_ROWS result beats;
// each row passes through two store reads, one multiply, one reciprocal multiply for the divide
// by OUT_ROWS-1 and the load, and waits at the load while the previous beat is not yet popped.
// Reset (rst_n low, asynchronous) releases the button, clears the count, queue and output;
// the sample store is not cleared.
module gesture_capture_resampler #(
    parameter int OUT_ROWS = gcr_pkg::DEF_OUT_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        button_pressed,
    input  logic                        sample_ok,
    input  logic signed [15:0]          accel_x,
    input  logic signed [15:0]          accel_y,
    input  logic signed [15:0]          accel_z,
    input  logic signed [15:0]          gyro_x,
    input  logic signed [15:0]          gyro_y,
    input  logic signed [15:0]          gyro_z,
    output logic                        empty,
    input  logic                        pop,
    output logic [gcr_pkg::ROW_W-1:0]   row_index,
    output logic signed [23:0]          out_accel_x,
    output logic signed [23:0]          out_accel_y,
    output logic signed [23:0]          out_accel_z,
    output logic signed [23:0]          out_gyro_x,
    output logic signed [23:0]          out_gyro_y,
    output logic signed [23:0]          out_gyro_z,
    output logic                        last_row
);
    import gcr_pkg::*;

    sample_vec_t samples;
    result_vec_t results;
    cmd_t        f_cmd;
    cmd_t        b_cmd;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;

    assign samples = {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x};
    assign out_accel_x = $signed(results[0]);
    assign out_accel_y = $signed(results[1]);
    assign out_accel_z = $signed(results[2]);
    assign out_gyro_x  = $signed(results[3]);
    assign out_gyro_y  = $signed(results[4]);
    assign out_gyro_z  = $signed(results[5]);

    gcr_front #(.OUT_ROWS(OUT_ROWS)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .button_pressed (button_pressed),
        .sample_ok      (sample_ok),
        .samples        (samples),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (f_cmd)
    );

    gcr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (f_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (b_cmd),
        .q_empty (q_empty)
    );

    gcr_back #(.OUT_ROWS(OUT_ROWS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (b_cmd),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .row_index (row_index),
        .results   (results),
        .last_row  (last_row)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

    a_last_row_index: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_row) |-> (row_index == ROW_W'(OUT_ROWS - 1)))
        else $error("last row flag on a row other than the final one");

    a_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(row_index) && $stable(out_accel_x)))
        else $error("waiting result beat changed before it was taken");

endmodule

### hdl/gcr_front.sv
`timescale 1ns / 1ps
module gcr_front #(
    parameter int OUT_ROWS = gcr_pkg::DEF_OUT_ROWS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                button_pressed,
    input  logic                sample_ok,
    input  gcr_pkg::sample_vec_t samples,
    input  logic                q_full,
    output logic                q_push,
    output gcr_pkg::cmd_t       q_cmd
);
    import gcr_pkg::*;

    logic             was_pressed_reg;
    logic             was_pressed_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_eff;
    logic             accept;
    logic             do_write;
    logic             do_run;

    assign full   = q_full;
    assign accept = push && !q_full;

    // classify the tick: press edge clears, held stores, release runs
    always_comb
    begin
        count_eff = (button_pressed && !was_pressed_reg) ? '0 : count_reg;
        do_write  = button_pressed && sample_ok && (count_eff < CNT_W'(OUT_ROWS));
        do_run    = was_pressed_reg && !button_pressed && (count_eff != '0);
        q_push    = accept && (do_write || do_run);
        q_cmd.kind = do_write ? CMD_WRITE : CMD_RUN;
        q_cmd.cnt  = count_eff;
        q_cmd.data = samples;
        was_pressed_next = accept ? button_pressed : was_pressed_reg;
        count_next = count_reg;
        if (accept)
        begin
            count_next = do_write ? count_eff + 1'b1 : count_eff;
        end
    end

    // hold edge and count state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            was_pressed_reg <= was_pressed_next;
            count_reg       <= count_next;
        end
    end

endmodule

### hdl/gcr_fifo.sv
`timescale 1ns / 1ps
module gcr_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  gcr_pkg::cmd_t wr_data,
    output logic          q_full,
    input  logic          rd_en,
    output gcr_pkg::cmd_t rd_data,
    output logic          q_empty
);
    import gcr_pkg::*;

    localparam int QAW = $clog2(QDEPTH);

    cmd_t             store_reg [QDEPTH];
    logic [QAW-1:0]   wptr_reg;
    logic [QAW-1:0]   rptr_reg;
    logic [QAW:0]     fill_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (fill_reg == (QAW+1)'(QDEPTH));
    assign q_empty = (fill_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = store_reg[rptr_reg];

    // write the entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wptr_reg] <= wr_data;
        end
    end

    // advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
        end
    end

endmodule

### hdl/gcr_back.sv
`timescale 1ns / 1ps
module gcr_back #(
    parameter int OUT_ROWS = gcr_pkg::DEF_OUT_ROWS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    input  gcr_pkg::cmd_t            q_cmd,
    output logic                     q_pop,
    output logic                     empty,
    input  logic                     pop,
    output logic [gcr_pkg::ROW_W-1:0] row_index,
    output gcr_pkg::result_vec_t     results,
    output logic                     last_row
);
    import gcr_pkg::*;

    localparam int AW  = (OUT_ROWS > 1) ? $clog2(OUT_ROWS) : 1;
    localparam int RW  = $clog2(2 * OUT_ROWS);
    localparam int PW  = SAMPLE_W + 1 + RW + 1;
    localparam int DEN = OUT_ROWS - 1;
    // reciprocal of DEN, exact for every dividend below 2^(DIV_W-1)
    localparam int RSH = DIV_W - 1 + $clog2(DEN);
    localparam logic [DIV_W-1:0] RECIP =
        DIV_W'(((64'd1 << RSH) + 64'(DEN) - 64'd1) / 64'(DEN));

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ0,
        S_READ1,
        S_MUL,
        S_DIV,
        S_EMIT
    } state_t;

    sample_vec_t     mem [OUT_ROWS];
    sample_vec_t     rdata_reg;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;

    state_t          state_reg;
    logic [AW-1:0]   row_reg;
    logic [AW-1:0]   idx_reg;
    logic [RW-1:0]   rem_reg;
    logic [CNT_W-1:0] n_reg;
    logic            out_valid_reg;
    logic [AW-1:0]   out_row_reg;
    logic            out_last_reg;

    sample_vec_t     v0_reg;
    logic [AXES-1:0][DIV_W-1:0] div_reg;
    logic [AXES-1:0][DIV_W-1:0] quo_reg;
    logic [AXES-1:0]            neg_reg;
    result_vec_t     out_data_reg;

    logic            load_out;
    logic            has_next;
    logic [RW-1:0]   rem_sum;
    logic [AXES-1:0][DIV_W-1:0] dividend;
    logic [AXES-1:0]            prod_neg;
    logic [AXES-1:0][DIV_W-1:0] quo_next;
    result_vec_t     res_next;

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign mem_we   = q_pop && (q_cmd.kind == CMD_WRITE);
    assign rd_addr  = (state_reg == S_READ0) ? idx_reg : idx_reg + 1'b1;
    assign has_next = (CNT_W'(idx_reg) + 1'b1) < n_reg;
    assign load_out = (state_reg == S_EMIT) && (!out_valid_reg || pop);
    assign rem_sum  = rem_reg + RW'(n_reg - 1'b1);

    assign empty     = !out_valid_reg;
    assign row_index = ROW_W'(out_row_reg);
    assign results   = out_data_reg;
    assign last_row  = out_last_reg;

    // sample store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_cmd.cnt[AW-1:0]] <= q_cmd.data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // per-axis datapath: difference times remainder, reciprocal divide, final sum
    always_comb
    begin
        logic signed [SAMPLE_W-1:0] v0;
        logic signed [SAMPLE_W-1:0] v1;
        logic signed [SAMPLE_W:0]   diff;
        logic signed [PW-1:0]       prod;
        logic [PW-1:0]              mag;
        logic [2*DIV_W-1:0]         qprod;
        logic                       rem_nz;
        logic signed [DIV_W+1:0]    fl;
        logic signed [DIV_W+1:0]    sum;
        for (int a = 0; a < AXES; a++)
        begin
            v0   = $signed(v0_reg[a]);
            v1   = has_next ? $signed(rdata_reg[a]) : v0;
            diff = (SAMPLE_W+1)'(v1) - (SAMPLE_W+1)'(v0);
            prod = PW'(diff) * PW'($signed({1'b0, rem_reg}));
            mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
            prod_neg[a] = prod[PW-1];
            dividend[a] = DIV_W'({mag, {FRAC_W{1'b0}}});

            // quotient by multiply with the scaled reciprocal
            qprod       = (2*DIV_W)'(div_reg[a]) * (2*DIV_W)'(RECIP);
            quo_next[a] = DIV_W'(qprod >> RSH);

            // round toward minus infinity for a negative product
            rem_nz = ((quo_reg[a] * DIV_W'(DEN)) != div_reg[a]);
            fl = $signed({2'b00, quo_reg[a]});
            if (neg_reg[a])
            begin
                fl = -(fl + (DIV_W+2)'(rem_nz));
            end
            sum = ((DIV_W+2)'(v0) <<< FRAC_W) + fl;
            res_next[a] = sum[OUT_W-1:0];
        end
    end

    // hold payload: first sample, dividend, quotient, result beat
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ1)
        begin
            v0_reg <= rdata_reg;
        end
        if (state_reg == S_MUL)
        begin
            div_reg <= dividend;
            neg_reg <= prod_neg;
        end
        if (state_reg == S_DIV)
        begin
            quo_reg <= quo_next;
        end
        if (load_out)
        begin
            out_data_reg <= res_next;
        end
    end

    // sequence the rows of a run and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            idx_reg       <= '0;
            rem_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && (q_cmd.kind == CMD_RUN))
                    begin
                        n_reg     <= q_cmd.cnt;
                        row_reg   <= '0;
                        idx_reg   <= '0;
                        rem_reg   <= '0;
                        state_reg <= S_READ0;
                    end
                end
                S_READ0:
                begin
                    state_reg <= S_READ1;
                end
                S_READ1:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        out_row_reg   <= row_reg;
                        out_last_reg  <= (row_reg == AW'(OUT_ROWS - 1));
                        if (row_reg == AW'(OUT_ROWS - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            // advance position by (n-1)/(OUT_ROWS-1)
                            row_reg <= row_reg + 1'b1;
                            if (rem_sum >= RW'(DEN))
                            begin
                                rem_reg <= rem_sum - RW'(DEN);
                                idx_reg <= idx_reg + 1'b1;
                            end
                            else
                            begin
                                rem_reg <= rem_sum;
                            end
                            state_reg <= S_READ0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/sv/gesture_capture_resampler_checker.sv
`timescale 1ns / 1ps
module gesture_capture_resampler_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic                      full,
    input  logic                      button_pressed,
    input  logic                      sample_ok,
    input  logic signed [15:0]        accel_x,
    input  logic signed [15:0]        accel_y,
    input  logic signed [15:0]        accel_z,
    input  logic signed [15:0]        gyro_x,
    input  logic signed [15:0]        gyro_y,
    input  logic signed [15:0]        gyro_z,
    input  logic                      empty,
    input  logic                      pop,
    input  logic [gcr_pkg::ROW_W-1:0] row_index,
    input  logic signed [23:0]        out_accel_x,
    input  logic signed [23:0]        out_accel_y,
    input  logic signed [23:0]        out_accel_z,
    input  logic signed [23:0]        out_gyro_x,
    input  logic signed [23:0]        out_gyro_y,
    input  logic signed [23:0]        out_gyro_z,
    input  logic                      last_row,
    output int                        mismatches,
    output int                        rows_pending
);
    import gcr_pkg::*;

    localparam int NROWS = DEF_OUT_ROWS;
    localparam int DEN   = NROWS - 1;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        result_vec_t      axis;
        logic             last;
    } row_beat_t;

    row_beat_t   expected_rows[$];
    logic        held_q;
    int          capture_count;
    sample_vec_t capture_store[NROWS];

    assign rows_pending = expected_rows.size();

    function automatic longint floor_div(longint num, longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // Append one full resampled run built from the captured samples
    task automatic queue_resampled_run(int n);
        row_beat_t b;
        int        num;
        int        idx;
        int        rem;
        longint    v0;
        longint    v1;
        longint    val;
        for (int i = 0; i < NROWS; i++)
        begin
            num = i * (n - 1);
            idx = num / DEN;
            rem = num % DEN;
            b.row = i[ROW_W-1:0];
            b.last = (i == NROWS - 1);
            for (int a = 0; a < AXES; a++)
            begin
                v0 = longint'($signed(capture_store[idx][a]));
                v1 = v0;
                if (idx + 1 < n)
                    v1 = longint'($signed(capture_store[idx + 1][a]));
                val = v0 * 256 + floor_div((v1 - v0) * rem * 256, DEN);
                b.axis[a] = val[OUT_W-1:0];
            end
            expected_rows.push_back(b);
        end
    endtask

    // Predict on each accepted tick, compare each accepted result beat
    always @(posedge clk or negedge rst_n)
    begin
        row_beat_t got;
        row_beat_t want;
        if (!rst_n)
        begin
            held_q = 1'b0;
            capture_count = 0;
            mismatches = 0;
            expected_rows.delete();
        end
        else
        begin
            if (push && !full)
            begin
                if (!held_q && button_pressed)
                    capture_count = 0;
                if (button_pressed && sample_ok && capture_count < NROWS)
                begin
                    capture_store[capture_count] =
                        {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x};
                    capture_count++;
                end
                if (held_q && !button_pressed && capture_count > 0)
                    queue_resampled_run(capture_count);
                held_q = button_pressed;
            end
            if (pop && !empty)
            begin
                got.row = row_index;
                got.axis = {out_gyro_z, out_gyro_y, out_gyro_x,
                            out_accel_z, out_accel_y, out_accel_x};
                got.last = last_row;
                if (expected_rows.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected beat: row %0d last %0b", got.row, got.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: exp row %0d %h last %0b, got row %0d %h last %0b",
                                     want.row, want.axis, want.last,
                                     got.row, got.axis, got.last);
                        mismatches++;
                    end
                end
            end
        end
    end
endmodule

### tb/sv/gesture_capture_resampler_tb.sv
`timescale 1ns / 1ps
module gesture_capture_resampler_tb;
    localparam int LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic button_pressed;
    logic sample_ok;
    logic signed [15:0] accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z;
    logic empty;
    logic pop;
    logic [gcr_pkg::ROW_W-1:0] row_index;
    logic signed [23:0] out_accel_x, out_accel_y, out_accel_z;
    logic signed [23:0] out_gyro_x, out_gyro_y, out_gyro_z;
    logic last_row;
    int   mismatches;
    int   rows_pending;
    int   cycles;
    int   ticks_sent;
    bit   hold_req;
    bit   hold_on;

    gesture_capture_resampler u_dut (.*);

    gesture_capture_resampler_checker u_chk (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Long receiver hold-off, counted here
    initial
    begin
        hold_on = 1'b0;
        wait (hold_req);
        hold_on = 1'b1;
        repeat (4000) @(posedge clk);
        hold_on = 1'b0;
    end

    // Receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_on)
            pop <= 1'b0;
        else if (cycles % 1000 < 300)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(0, 3) != 0);
    end

    function automatic logic [15:0] motion_value();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one tick and hold it until accepted; afterwards push stays high or drops for a random pause
    task automatic send_tick(logic btn, logic ok);
        push <= 1'b1;
        button_pressed <= btn;
        sample_ok <= ok;
        accel_x <= motion_value();
        accel_y <= motion_value();
        accel_z <= motion_value();
        gyro_x <= motion_value();
        gyro_y <= motion_value();
        gyro_z <= motion_value();
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        @(negedge clk);
        ticks_sent++;
        if ($urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clk);
        end
    endtask

    task automatic send_gesture(int len, int ok_pct);
        for (int k = 0; k < len; k++)
            send_tick(1'b1, $urandom_range(1, 100) <= ok_pct);
        send_tick(1'b0, 1'($urandom));
    endtask

    initial
    begin
        int len;
        cycles = 0;
        ticks_sent = 0;
        hold_req = 1'b0;
        pop = 1'b0;
        push = 1'b0;
        button_pressed = 1'b0;
        sample_ok = 1'b0;
        {accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z} = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: release with no samples, single sample, extremes, failed reads
        send_tick(1'b0, 1'b1);
        send_gesture(2, 0);
        send_gesture(1, 100);
        send_gesture(2, 100);
        send_gesture(3, 50);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);

        // Pause until every result has drained
        push <= 1'b0;
        wait (rows_pending == 0);
        @(negedge clk);
        hold_req = 1'b1;

        // Random gestures with noise between them
        while (ticks_sent < 220)
        begin
            case ($urandom_range(0, 9))
                0: send_tick(1'b0, 1'($urandom));
                1: send_gesture($urandom_range(60, 70), 95);
                2: send_gesture($urandom_range(1, 4), 0);
                default:
                begin
                    len = $urandom_range(1, 10);
                    send_gesture(len, 85);
                end
            endcase
        end
        push <= 1'b0;

        wait (rows_pending == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && rows_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### gesture_capture_resampler.f
hdl/gcr_pkg.sv
hdl/gcr_front.sv
hdl/gcr_fifo.sv
hdl/gcr_back.sv
hdl/gesture_capture_resampler.sv
tb/sv/gesture_capture_resampler_checker.sv
tb/sv/gesture_capture_resampler_tb.sv
